// ===== hw/rtl/keyed_usage_counter_table_macros.svh =====
// Assertion macros for the keyed usage counter table.
// No dependencies; included by the top level.
`ifndef KEYED_USAGE_COUNTER_TABLE_MACROS_SVH
`define KEYED_USAGE_COUNTER_TABLE_MACROS_SVH

// Assert that prop holds on every clock edge outside reset.
`define KUCT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assert that prop holds on every clock edge, reset included.
`define KUCT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/kuct_pkg.sv =====
// Package for the keyed usage counter table: types, status codes, sizes.
// No dependencies.
package kuct_pkg;

    localparam int unsigned SLOTS_DEF = 16;
    localparam int unsigned ENTRY_W   = 64 + 8 + 32 + 32;

    typedef enum logic [1:0] {
        MODE_USE    = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_LIST   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_INCR     = 3'd0,
        ST_INSERTED = 3'd1,
        ST_TIME     = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5,
        ST_LISTED   = 3'd6,
        ST_EMPTY    = 3'd7
    } status_t;

    typedef struct packed {
        logic [63:0] key_head;
        logic [7:0]  key_tail;
        logic [31:0] uses;
        logic [31:0] secs;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CMP,
        S_DISPATCH,
        S_WRITE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SORT_RDI,
        S_SORT_RDJ,
        S_SORT_CMP,
        S_SORT_WRI,
        S_LIST_RD,
        S_LIST_OUT,
        S_OUT
    } state_t;

    // Clear every byte after the first zero byte of the nine-byte name.
    function automatic logic [71:0] clean_key(input logic [63:0] kh, input logic [7:0] kt);
        logic [71:0] k;
        logic        z;
        k = {kt, kh};
        z = 1'b0;
        for (int b = 0; b < 9; b++) begin
            if (z) begin
                k[8*b +: 8] = 8'd0;
            end else if (k[8*b +: 8] == 8'd0) begin
                z = 1'b1;
            end
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/kuct_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module kuct_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/kuct_seq.sv =====
// Sequencer for the keyed usage counter table: search, update, shift, sort, list.
// Depends on kuct_pkg and kuct_ram.
module kuct_seq
    import kuct_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         req_valid,
    output logic         req_ready,
    input  logic [1:0]   req_mode,
    input  logic [63:0]  req_key_head,
    input  logic [7:0]   req_key_tail,
    input  logic [31:0]  req_seconds,
    output logic         res_valid,
    input  logic         res_ready,
    output logic [2:0]   res_status,
    output entry_t       res_entry,
    output logic         res_last,
    output state_t       state_o,
    output logic [$clog2(SLOTS+1)-1:0] occ_o
);
    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned CW = $clog2(SLOTS+1);

    state_t state_reg, state_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic [1:0]    mode_reg, mode_next;
    logic [71:0]   key_reg, key_next;
    logic [31:0]   secs_reg, secs_next;
    logic          hit_reg, hit_next;
    entry_t        hold_reg, hold_next;      // entry found or entry i in sort
    logic [2:0]    st_reg, st_next;
    entry_t        out_reg, out_next;
    logic          last_reg, last_next;

    logic          we;
    logic [AW-1:0] addr;
    entry_t        wdata, rdata;

    kuct_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS)) u_ram (
        .aclk (aclk),
        .we   (we),
        .addr (addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
        i_reg    <= i_next;
        j_reg    <= j_next;
        mode_reg <= mode_next;
        key_reg  <= key_next;
        secs_reg <= secs_next;
        hit_reg  <= hit_next;
        hold_reg <= hold_next;
        st_reg   <= st_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        occ_next   = occ_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        mode_next  = mode_reg;
        key_next   = key_reg;
        secs_next  = secs_reg;
        hit_next   = hit_reg;
        hold_next  = hold_reg;
        st_next    = st_reg;
        out_next   = out_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE: begin
                if (req_valid) begin
                    mode_next = req_mode;
                    key_next  = clean_key(req_key_head, req_key_tail);
                    secs_next = req_seconds;
                    i_next    = '0;
                    hit_next  = 1'b0;
                    if (req_mode == MODE_LIST) begin
                        if (occ_reg == '0) begin
                            st_next    = ST_EMPTY;
                            out_next   = '0;
                            last_next  = 1'b1;
                            state_next = S_OUT;
                        end else begin
                            state_next = S_SORT_RDI;
                        end
                    end else if (occ_reg == '0) begin
                        state_next = S_DISPATCH;
                    end else begin
                        state_next = S_FIND_RD;
                    end
                end
            end
            S_FIND_RD: state_next = S_FIND_CMP;
            S_FIND_CMP: begin
                if ({rdata.key_tail, rdata.key_head} == key_reg) begin
                    hit_next   = 1'b1;
                    hold_next  = rdata;
                    state_next = S_DISPATCH;
                end else if (i_reg + 1'b1 == occ_reg) begin
                    state_next = S_DISPATCH;
                end else begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_FIND_RD;
                end
            end
            S_DISPATCH: begin
                last_next         = 1'b1;
                out_next.key_head = key_reg[63:0];
                out_next.key_tail = key_reg[71:64];
                out_next.uses     = '0;
                out_next.secs     = '0;
                state_next        = S_OUT;
                case (mode_reg)
                    MODE_USE: begin
                        if (hit_reg) begin
                            hold_next.uses = (hold_reg.uses == 32'hFFFF_FFFF) ?
                                             hold_reg.uses : hold_reg.uses + 32'd1;
                            st_next    = ST_INCR;
                            state_next = S_WRITE;
                        end else if (occ_reg == CW'(SLOTS)) begin
                            st_next = ST_FULL;
                        end else begin
                            hold_next.key_head = key_reg[63:0];
                            hold_next.key_tail = key_reg[71:64];
                            hold_next.uses     = 32'd1;
                            hold_next.secs     = '0;
                            i_next     = occ_reg;
                            occ_next   = occ_reg + 1'b1;
                            st_next    = ST_INSERTED;
                            state_next = S_WRITE;
                        end
                    end
                    MODE_ADD: begin
                        if (hit_reg) begin
                            hold_next.secs = hold_reg.secs + secs_reg;
                            st_next        = ST_TIME;
                            state_next     = S_WRITE;
                        end else begin
                            st_next = ST_NOTFOUND;
                        end
                    end
                    MODE_REMOVE: begin
                        if (hit_reg) begin
                            st_next       = ST_REMOVED;
                            out_next.uses = hold_reg.uses;
                            out_next.secs = hold_reg.secs;
                            occ_next      = occ_reg - 1'b1;
                            state_next    = (i_reg + 1'b1 == occ_reg) ? S_OUT : S_SHIFT_RD;
                        end else begin
                            st_next = ST_NOTFOUND;
                        end
                    end
                    default: st_next = ST_NOTFOUND;
                endcase
            end
            S_WRITE: begin
                out_next.uses = hold_reg.uses;
                out_next.secs = hold_reg.secs;
                state_next    = S_OUT;
            end
            S_SHIFT_RD: state_next = S_SHIFT_WR;
            S_SHIFT_WR: begin
                i_next     = i_reg + 1'b1;
                state_next = (i_reg + 2'd2 > occ_reg) ? S_OUT : S_SHIFT_RD;
            end
            S_SORT_RDI: begin
                j_next     = i_reg + 1'b1;
                state_next = (i_reg + 1'b1 >= occ_reg) ? S_LIST_RD : S_SORT_RDJ;
                if (i_reg + 1'b1 >= occ_reg) begin
                    i_next = '0;
                end
            end
            S_SORT_RDJ: begin
                hold_next  = (j_reg == i_reg + 1'b1) ? rdata : hold_reg;
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP: begin
                if (hold_reg.uses < rdata.uses) begin
                    hold_next  = rdata;
                    out_next   = hold_reg;    // old entry i goes to slot j
                    state_next = S_SORT_WRI;
                end else if (j_reg + 1'b1 == occ_reg) begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SORT_RDI;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SORT_RDJ;
                end
            end
            S_SORT_WRI: begin
                if (j_reg + 1'b1 == occ_reg) begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_SORT_RDI;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_SORT_RDJ;
                end
            end
            S_LIST_RD: state_next = S_LIST_OUT;
            S_LIST_OUT: begin
                out_next   = rdata;
                st_next    = ST_LISTED;
                last_next  = (i_reg + 1'b1 == occ_reg);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (res_ready) begin
                    if (mode_reg == MODE_LIST && !last_reg) begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_LIST_RD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        we    = 1'b0;
        addr  = i_reg[AW-1:0];
        wdata = hold_reg;
        case (state_reg)
            S_WRITE: we = 1'b1;
            S_SHIFT_RD: addr = AW'(i_reg + 1'b1);
            S_SHIFT_WR: begin
                we    = 1'b1;
                wdata = rdata;
            end
            S_SORT_RDJ: addr = j_reg[AW-1:0];
            S_SORT_CMP: begin
                // write new entry i on swap
                if (hold_reg.uses < rdata.uses) begin
                    we    = 1'b1;
                    wdata = rdata;
                end
            end
            S_SORT_WRI: begin
                we    = 1'b1;
                addr  = j_reg[AW-1:0];
                wdata = out_reg;
            end
            default: ;
        endcase
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT);
    assign res_status = st_reg;
    assign res_entry  = out_reg;
    assign res_last   = last_reg;
    assign state_o    = state_reg;
    assign occ_o      = occ_reg;
endmodule

// ===== hw/rtl/keyed_usage_counter_table.sv =====
// Keyed usage counter table: one request at a time, answered from a slot RAM
// by a sequencer that walks the slots; use, add time, remove, sort-and-list.
// Lookups and removes read the single RAM port once per slot; a list request
// first runs an exchange sort over the N entries, reading entry j for each
// compare and writing entries i and j on a swap, then reads out each listed entry.
// s_axis_tready is high only while no request is in progress.
`include "keyed_usage_counter_table_macros.svh"
module keyed_usage_counter_table
    import kuct_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [111:0]  s_axis_tdata,  // key_head[63:0], key_tail[71:64], seconds[103:72]
    input  logic [1:0]    s_axis_tuser,  // mode
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [135:0]  m_axis_tdata,  // out_key_head, out_key_tail, use_count, time_total
    output logic [2:0]    m_axis_tuser,  // status
    output logic          m_axis_tlast
);
    entry_t        res_entry;
    state_t        state;
    logic [$clog2(SLOTS+1)-1:0] occ;

    kuct_seq #(.SLOTS(SLOTS)) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_axis_tvalid),
        .req_ready   (s_axis_tready),
        .req_mode    (s_axis_tuser),
        .req_key_head(s_axis_tdata[63:0]),
        .req_key_tail(s_axis_tdata[71:64]),
        .req_seconds (s_axis_tdata[103:72]),
        .res_valid   (m_axis_tvalid),
        .res_ready   (m_axis_tready),
        .res_status  (m_axis_tuser),
        .res_entry   (res_entry),
        .res_last    (m_axis_tlast),
        .state_o     (state),
        .occ_o       (occ)
    );

    assign m_axis_tdata = {res_entry.secs, res_entry.uses, res_entry.key_tail,
                           res_entry.key_head};

    `KUCT_ASSERT(a_occ_range, aclk, aresetn, occ <= ($clog2(SLOTS+1))'(SLOTS), "occupancy above SLOTS")
    `KUCT_ASSERT(a_no_overlap, aclk, aresetn, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
    `KUCT_ASSERT(a_full_stable, aclk, aresetn, (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> occ == ($clog2(SLOTS+1))'(SLOTS), "full status with room left")
    `KUCT_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> state == S_IDLE, "not idle after reset")
endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for keyed_usage_counter_table: streams requests, predicts every
// answer with an in-bench copy of the slot table and compares field by field.
// Depends on kuct_pkg and the keyed_usage_counter_table RTL.
module tb;
    import kuct_pkg::*;

    localparam int NSLOT     = 16;
    localparam int STALL_PCT = 17;
    localparam int WD_LIMIT  = 40000;

    typedef struct {
        mode_t       mode;
        logic [63:0] kh;
        logic [7:0]  kt;
        logic [31:0] secs;
        bit          hold;   // wait for every answer before this request goes out
    } request_t;

    typedef struct {
        status_t     st;
        logic [63:0] kh;
        logic [7:0]  kt;
        logic [31:0] uses;
        logic [31:0] secs;
        logic        last;
    } answer_t;

    logic          aclk = 1'b0;
    logic          aresetn = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [111:0]  s_axis_tdata = '0;   // key_head, key_tail, seconds
    logic [1:0]    s_axis_tuser = '0;   // mode
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [135:0]  m_axis_tdata;        // key_head, key_tail, use_count, time_total
    logic [2:0]    m_axis_tuser;        // status
    logic          m_axis_tlast;

    request_t    pending_reqs[$];
    answer_t     due_answers[$];
    int          sent = 0;
    int          errors = 0;
    bit          calm;

    // shadow table
    logic [63:0] tab_kh[NSLOT];
    logic [7:0]  tab_kt[NSLOT];
    logic [31:0] tab_uses[NSLOT];
    logic [31:0] tab_secs[NSLOT];
    int          n_used = 0;

    // key pool
    logic [63:0] pool_kh[24];
    logic [7:0]  pool_kt[24];
    int          pool_len[24];

    keyed_usage_counter_table i_dut (.*);

    always #4 aclk = ~aclk;

    assign calm = (sent >= 200 && sent < 280);

    function automatic answer_t mk(status_t st, logic [63:0] kh, logic [7:0] kt,
                                   logic [31:0] u, logic [31:0] s, logic l);
        answer_t a;
        a.st = st; a.kh = kh; a.kt = kt; a.uses = u; a.secs = s; a.last = l;
        return a;
    endfunction

    // Work out the answers to one request and update the shadow table.
    task automatic predict_answers(request_t r);
        logic [63:0] kh;
        logic [7:0]  kt;
        logic [63:0] th;
        logic [7:0]  tt;
        logic [31:0] tu, tsec;
        bit          cut;
        int          hit;
        kh = r.kh; kt = r.kt; cut = 0; hit = -1;
        // name is a C string: everything after the first zero byte is dropped
        for (int b = 0; b < 8; b++) begin
            if (!cut && kh[8*b +: 8] == 8'd0) begin
                cut = 1;
                for (int c = b; c < 8; c++) kh[8*c +: 8] = 8'd0;
                kt = 8'd0;
            end
        end
        for (int i = n_used - 1; i >= 0; i--)
            if (tab_kh[i] == kh && tab_kt[i] == kt) hit = i;
        case (r.mode)
            MODE_USE: begin
                if (hit >= 0) begin
                    if (tab_uses[hit] != 32'hFFFF_FFFF) tab_uses[hit]++;
                    due_answers.push_back(mk(ST_INCR, kh, kt, tab_uses[hit], tab_secs[hit], 1));
                end else if (n_used >= NSLOT) begin
                    due_answers.push_back(mk(ST_FULL, kh, kt, 0, 0, 1));
                end else begin
                    tab_kh[n_used] = kh; tab_kt[n_used] = kt;
                    tab_uses[n_used] = 1; tab_secs[n_used] = 0;
                    n_used++;
                    due_answers.push_back(mk(ST_INSERTED, kh, kt, 1, 0, 1));
                end
            end
            MODE_ADD: begin
                if (hit < 0) begin
                    due_answers.push_back(mk(ST_NOTFOUND, kh, kt, 0, 0, 1));
                end else begin
                    tab_secs[hit] = tab_secs[hit] + r.secs;
                    due_answers.push_back(mk(ST_TIME, kh, kt, tab_uses[hit], tab_secs[hit], 1));
                end
            end
            MODE_REMOVE: begin
                if (hit < 0) begin
                    due_answers.push_back(mk(ST_NOTFOUND, kh, kt, 0, 0, 1));
                end else begin
                    due_answers.push_back(mk(ST_REMOVED, kh, kt, tab_uses[hit], tab_secs[hit], 1));
                    for (int i = hit; i + 1 < n_used; i++) begin
                        tab_kh[i] = tab_kh[i+1]; tab_kt[i] = tab_kt[i+1];
                        tab_uses[i] = tab_uses[i+1]; tab_secs[i] = tab_secs[i+1];
                    end
                    n_used--;
                end
            end
            default: begin
                if (n_used == 0) begin
                    due_answers.push_back(mk(ST_EMPTY, 0, 0, 0, 0, 1));
                end else begin
                    // exchange sort, descending count, order kept in the table
                    for (int i = 0; i < n_used; i++)
                        for (int j = i + 1; j < n_used; j++)
                            if (tab_uses[i] < tab_uses[j]) begin
                                th = tab_kh[i]; tt = tab_kt[i]; tu = tab_uses[i]; tsec = tab_secs[i];
                                tab_kh[i] = tab_kh[j]; tab_kt[i] = tab_kt[j];
                                tab_uses[i] = tab_uses[j]; tab_secs[i] = tab_secs[j];
                                tab_kh[j] = th; tab_kt[j] = tt; tab_uses[j] = tu; tab_secs[j] = tsec;
                            end
                    for (int i = 0; i < n_used; i++)
                        due_answers.push_back(mk(ST_LISTED, tab_kh[i], tab_kt[i], tab_uses[i],
                                                 tab_secs[i], i + 1 == n_used));
                end
            end
        endcase
    endtask

    // Driver: next request goes out once the previous one is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_reqs.size() == 0 || (pending_reqs[0].hold && due_answers.size() != 0)
                || (!calm && $urandom_range(99) < STALL_PCT)) begin
                s_axis_tvalid <= 1'b0;
            end else begin
                request_t r;
                r = pending_reqs.pop_front();
                predict_answers(r);
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= r.mode;
                s_axis_tdata  <= {8'd0, r.secs, r.kt, r.kh};
                sent <= sent + 1;
            end
        end
    end

    // Monitor: random back-pressure and the checks.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= STALL_PCT);
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_answers.size() == 0) begin
                    $error("unexpected answer, status %0d", m_axis_tuser);
                    errors++;
                end else begin
                    answer_t e;
                    e = due_answers.pop_front();
                    if (m_axis_tuser !== e.st) begin
                        $error("status: expected %0d, got %0d", e.st, m_axis_tuser); errors++;
                    end
                    if (m_axis_tdata[63:0] !== e.kh) begin
                        $error("out_key_head: expected %h, got %h", e.kh, m_axis_tdata[63:0]);
                        errors++;
                    end
                    if (m_axis_tdata[71:64] !== e.kt) begin
                        $error("out_key_tail: expected %h, got %h", e.kt, m_axis_tdata[71:64]);
                        errors++;
                    end
                    if (m_axis_tdata[103:72] !== e.uses) begin
                        $error("use_count: expected %0d, got %0d", e.uses, m_axis_tdata[103:72]);
                        errors++;
                    end
                    if (m_axis_tdata[135:104] !== e.secs) begin
                        $error("time_total: expected %h, got %h", e.secs, m_axis_tdata[135:104]);
                        errors++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("last: expected %0d, got %0d", e.last, m_axis_tlast); errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side.
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_LIMIT) begin
            $display("keyed_usage_counter_table test failed");
            $finish;
        end
    end

    function automatic request_t req(mode_t m, logic [63:0] kh, logic [7:0] kt,
                                     logic [31:0] s, bit hold);
        request_t r;
        r.mode = m; r.kh = kh; r.kt = kt; r.secs = s; r.hold = hold;
        return r;
    endfunction

    // Pool key p, with junk after the terminator when asked.
    function automatic request_t pool_req(mode_t m, int p, bit junk);
        logic [63:0] kh;
        logic [7:0]  kt;
        kh = pool_kh[p]; kt = pool_kt[p];
        if (junk && pool_len[p] < 9) begin
            for (int b = pool_len[p] + 1; b < 8; b++) kh[8*b +: 8] = 8'($urandom);
            kt = 8'($urandom);
        end
        return req(m, kh, kt, $urandom, 0);
    endfunction

    initial begin
        int m;
        for (int p = 0; p < 24; p++) begin
            pool_len[p] = (p < 4) ? 9 : $urandom_range(0, 9);
            pool_kh[p] = '0; pool_kt[p] = '0;
            for (int b = 0; b < pool_len[p]; b++) begin
                if (b < 8) pool_kh[p][8*b +: 8] = 8'($urandom_range(1, 255));
                else       pool_kt[p] = 8'($urandom_range(1, 255));
            end
        end
        // directed part
        pending_reqs.push_back(req(MODE_LIST, 0, 0, 0, 0));              // empty list
        pending_reqs.push_back(req(MODE_REMOVE, 64'h41, 0, 0, 0));       // absent
        pending_reqs.push_back(req(MODE_ADD, 64'h41, 0, 5, 0));          // absent
        pending_reqs.push_back(req(MODE_USE, '1, 8'hFF, 0, 0));          // nine 0xFF bytes
        pending_reqs.push_back(req(MODE_USE, '1, 8'hFF, 0, 0));
        pending_reqs.push_back(req(MODE_ADD, '1, 8'hFF, 32'h7FFF_FFFF, 0));
        pending_reqs.push_back(req(MODE_ADD, '1, 8'hFF, 32'd1, 0));      // reaches 0x8000_0000
        pending_reqs.push_back(req(MODE_ADD, '1, 8'hFF, 32'h8000_0000, 0));
        pending_reqs.push_back(req(MODE_USE, 64'hFFFF_FF00_0000_4142, 8'hAA, 0, 0)); // junk
        pending_reqs.push_back(req(MODE_USE, 64'h4142, 0, 0, 0));        // same name, clean
        pending_reqs.push_back(req(MODE_USE, 64'hDEAD_BEEF_0000_0000, 8'h11, 0, 0)); // empty name
        pending_reqs.push_back(req(MODE_ADD, 0, 0, 32'hFFFF_FFFF, 0));
        pending_reqs.push_back(req(MODE_LIST, 0, 0, 0, 0));
        for (int p = 0; p < 15; p++)                                     // fill, then full
            pending_reqs.push_back(pool_req(MODE_USE, p + 4, 0));
        pending_reqs.push_back(req(MODE_LIST, 0, 0, 0, 0));
        pending_reqs.push_back(req(MODE_REMOVE, 64'h4142, 0, 0, 0));
        pending_reqs.push_back(req(MODE_REMOVE, '1, 8'hFF, 0, 0));
        pending_reqs.push_back(req(MODE_LIST, 0, 0, 0, 0));
        // random part, first request waits for the table to go quiet
        for (int n = 0; n < 400; n++) begin
            m = $urandom_range(99);
            if (m < 45)      pending_reqs.push_back(pool_req(MODE_USE, $urandom_range(23),
                                                            1'($urandom_range(1))));
            else if (m < 70) pending_reqs.push_back(pool_req(MODE_ADD, $urandom_range(23),
                                                            1'($urandom_range(1))));
            else if (m < 90) pending_reqs.push_back(pool_req(MODE_REMOVE, $urandom_range(23),
                                                            1'($urandom_range(1))));
            else             pending_reqs.push_back(req(MODE_LIST, {$urandom, $urandom},
                                                        8'($urandom), $urandom, 0));
            if (n == 0) pending_reqs[pending_reqs.size() - 1].hold = 1;
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_reqs.size() != 0) @(posedge aclk);
        @(posedge aclk);
        while (s_axis_tvalid || due_answers.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("keyed_usage_counter_table test passed");
        else
            $display("keyed_usage_counter_table test failed");
        $finish;
    end
endmodule

// ===== keyed_usage_counter_table.f =====
+incdir+hw/rtl
hw/rtl/kuct_pkg.sv
hw/rtl/kuct_ram.sv
hw/rtl/kuct_seq.sv
hw/rtl/keyed_usage_counter_table.sv
sim/tb.sv
